/* rtl/lpdc_pkg.sv */
// ----------------------------------------------------------------------------
// lpdc_pkg
// Shared types, constants and SHA-384 helpers for the launch page digest chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lpdc_pkg;

    localparam int          PAGE_WORDS = 512;
    localparam logic [7:0]  RECORD_LEN = 8'h70;
    localparam logic [63:0] PAD_MARK   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] RECORD_BIT_LEN = 64'(RECORD_LEN) << 3;

    typedef enum logic [1:0] {
        ACT_WORD  = 2'd0,
        ACT_EMPTY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_FIN,
        ST_PAD,
        ST_REC1,
        ST_REC2,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN,
        SRC_CHAIN,
        SRC_HASH,
        SRC_TYPE,
        SRC_ADDR,
        SRC_RLEN
    } t_src;

    typedef struct packed {
        logic       shift;
        t_src       src;
        logic [2:0] idx;
        logic [9:0] words;
        logic       capture;
        logic       restart;
        logic       clear;
        logic       init;
        logic       round;
        logic [6:0] rnd;
        logic       fin;
        logic       commit;
    } t_dp_cmd;

    function automatic logic [63:0] swap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i*8 +: 8] = x[(7-i)*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] start_h(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0:    v = 64'hcbbb9d5dc1059ed8;
            3'd1:    v = 64'h629a292a367cd507;
            3'd2:    v = 64'h9159015a3070dd17;
            3'd3:    v = 64'h152fecd8f70e5939;
            3'd4:    v = 64'h67332667ffc00b31;
            3'd5:    v = 64'h8eb44a8768581511;
            3'd6:    v = 64'hdb0c2e0d64f98fa7;
            default: v = 64'h47b5481dbefa4fa4;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        case (i)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* rtl/lpdc_if.sv */
// ----------------------------------------------------------------------------
// lpdc_in_if / lpdc_out_if
// Valid/ready channels for page beats in and digest beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] data_word;
    logic        word_last;
    logic [2:0]  page_kind;
    logic [63:0] guest_address;

    modport source (output valid, action, data_word, word_last, page_kind, guest_address,
                    input ready);
    modport sink   (input valid, action, data_word, word_last, page_kind, guest_address,
                    output ready);
endinterface

interface lpdc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;

    modport source (output valid, digest_word, digest_index, last_word, input ready);
    modport sink   (input valid, digest_word, digest_index, last_word, output ready);
endinterface

`default_nettype wire

/* rtl/lpdc_ctrl.sv */
// ----------------------------------------------------------------------------
// lpdc_ctrl
// Sequencer: word counting, padding, record build, round count, output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module lpdc_ctrl
    import lpdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_action,
    input  wire logic       i_in_last,
    output logic            o_in_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_out_index,
    output logic            o_out_last,
    output t_dp_cmd         o_cmd
);

    t_state     r_state, n_state, r_ret, n_ret;
    logic [3:0] r_fill, n_fill;
    logic [9:0] r_count, n_count;
    logic [6:0] r_rnd, n_rnd;
    logic [2:0] r_oidx, n_oidx;
    logic       r_mark, n_mark, r_late, n_late, r_empty, n_empty;
    logic [9:0] cnt_inc;
    logic       page_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_mark  <= 1'b0;
            r_late  <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_mark  <= n_mark;
            r_late  <= n_late;
            r_empty <= n_empty;
        end
    end

    assign cnt_inc  = r_count + 10'd1;
    assign page_end = i_in_last || (cnt_inc >= 10'(PAGE_WORDS));

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_count = r_count;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_mark  = r_mark;
        n_late  = r_late;
        n_empty = r_empty;
        o_cmd       = '0;
        o_cmd.src   = SRC_ZERO;
        o_cmd.idx   = r_oidx;
        o_cmd.words = r_count;
        o_cmd.rnd   = r_rnd;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (t_action'(i_in_action))
                        ACT_WORD: begin
                            o_cmd.shift   = 1'b1;
                            o_cmd.src     = SRC_DATA;
                            o_cmd.capture = 1'b1;
                            n_fill  = r_fill + 4'd1;
                            n_count = cnt_inc;
                            n_empty = 1'b0;
                            n_mark  = 1'b0;
                            n_late  = 1'b0;
                            if (r_fill == 4'd15) begin
                                n_state = ST_INIT;
                                n_ret   = page_end ? ST_PAD : ST_IDLE;
                            end else if (page_end) begin
                                n_state = ST_PAD;
                            end
                        end
                        ACT_EMPTY: begin
                            o_cmd.capture = 1'b1;
                            o_cmd.restart = 1'b1;
                            n_count = '0;
                            n_fill  = '0;
                            n_empty = 1'b1;
                            n_state = ST_REC1;
                        end
                        ACT_CLEAR: begin
                            o_cmd.clear   = 1'b1;
                            o_cmd.restart = 1'b1;
                            n_count = '0;
                            n_fill  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == 7'd79) begin
                    n_state = ST_FIN;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_ret;
            end
            ST_PAD: begin
                o_cmd.shift = 1'b1;
                n_fill = r_fill + 4'd1;
                n_mark = 1'b1;
                if (!r_mark) begin
                    o_cmd.src = SRC_MARK;
                    n_late    = (r_fill >= 4'd14);
                end else if (r_fill == 4'd15 && !r_late) begin
                    o_cmd.src = SRC_LEN;
                end
                if (r_fill == 4'd15) begin
                    n_late  = 1'b0;
                    n_state = ST_INIT;
                    n_ret   = (r_mark && !r_late) ? ST_REC1 : ST_PAD;
                end
            end
            ST_REC1: begin
                o_cmd.shift = 1'b1;
                n_fill = r_fill + 4'd1;
                if (r_fill < 4'd6) begin
                    o_cmd.src = SRC_CHAIN;
                    o_cmd.idx = r_fill[2:0];
                end else if (r_fill < 4'd12) begin
                    o_cmd.src = r_empty ? SRC_ZERO : SRC_HASH;
                    o_cmd.idx = 3'(r_fill - 4'd6);
                end else if (r_fill == 4'd12) begin
                    o_cmd.src = SRC_TYPE;
                end else if (r_fill == 4'd13) begin
                    o_cmd.src = SRC_ADDR;
                end else if (r_fill == 4'd14) begin
                    o_cmd.src = SRC_MARK;
                end else begin
                    o_cmd.restart = 1'b1;
                    n_count = '0;
                    n_state = ST_INIT;
                    n_ret   = ST_REC2;
                end
            end
            ST_REC2: begin
                o_cmd.shift = 1'b1;
                n_fill = r_fill + 4'd1;
                if (r_fill == 4'd15) begin
                    o_cmd.src = SRC_RLEN;
                    n_oidx    = '0;
                    n_state   = ST_INIT;
                    n_ret     = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_oidx == 3'd5) begin
                        o_cmd.commit = 1'b1;
                        n_oidx  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_index = r_oidx;
    assign o_out_last  = (r_oidx == 3'd5);

endmodule

`default_nettype wire

/* rtl/lpdc_dp.sv */
// ----------------------------------------------------------------------------
// lpdc_dp
// SHA-384 round datapath: message window, working variables, hash and chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpdc_dp
    import lpdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [63:0] i_data_word,
    input  wire logic [2:0]  i_page_kind,
    input  wire logic [63:0] i_guest_address,
    input  wire logic [2:0]  i_out_index,
    output logic [63:0]      o_digest_word
);

    logic [63:0] r_w [16];
    logic [63:0] r_v [8];
    logic [63:0] r_h [8];
    logic [63:0] r_chain [6];
    logic [2:0]  r_type;
    logic [63:0] r_addr;

    logic [63:0] word_in, sched, t1, t2, big_s0, big_s1, ch, maj;

    always_comb begin
        case (i_cmd.src)
            SRC_DATA:  word_in = swap64(i_data_word);
            SRC_MARK:  word_in = PAD_MARK;
            SRC_LEN:   word_in = {48'd0, i_cmd.words, 6'd0};
            SRC_CHAIN: word_in = swap64(r_chain[i_cmd.idx]);
            SRC_HASH:  word_in = r_h[i_cmd.idx];
            SRC_TYPE:  word_in = {RECORD_LEN, 13'd0, r_type, 40'd0};
            SRC_ADDR:  word_in = swap64(r_addr);
            SRC_RLEN:  word_in = RECORD_BIT_LEN;
            default:   word_in = '0;
        endcase
    end

    assign sched  = r_w[0] + (rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7))
                  + r_w[9] + (rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6));
    assign big_s1 = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
    assign big_s0 = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
    assign ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_s1 + ch + round_k(i_cmd.rnd) + r_w[0];
    assign t2     = big_s0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_cmd.round ? sched : word_in;
        end
        if (i_cmd.capture) begin
            r_type <= i_page_kind;
            r_addr <= i_guest_address;
        end
        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= start_h(3'(i));
            end
            for (int i = 0; i < 6; i++) begin
                r_chain[i] <= '0;
            end
        end else begin
            if (i_cmd.restart || i_cmd.commit) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= start_h(3'(i));
                end
            end else if (i_cmd.fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < 6; i++) begin
                    r_chain[i] <= '0;
                end
            end else if (i_cmd.commit) begin
                for (int i = 0; i < 6; i++) begin
                    r_chain[i] <= swap64(r_h[i]);
                end
            end
        end
    end

    assign o_digest_word = swap64(r_h[i_out_index]);

endmodule

`default_nettype wire

/* rtl/launch_page_digest_chain.sv */
// ----------------------------------------------------------------------------
// launch_page_digest_chain
// SHA-384 launch measurement chain over pages of 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   i_in beats carry one action each. A content word is shifted into the
//   message window, except every sixteenth word of a page, which also starts
//   a block compression (load, 80 rounds, add) while i_in.ready is low.
//   On the final word (or at the page length limit) the block pads the page
//   (one padding word per free slot of the last block, 1 to 16, then its
//   compression; a further block of zeros and length when fewer than three
//   slots are free), then builds and hashes the 112-byte record (two
//   blocks). An empty-page beat goes straight to the record. Clear and the
//   unused action produce nothing.
//   The new digest then leaves on o_out as six beats, index 0..5, last_word on
//   beat 5. The beats are read straight from the hash registers; while the
//   receiver stalls they hold and no input beat is taken.
//   Content words are bound by the single one-round-per-cycle SHA-384
//   compression unit, which holds off input while it runs.
//   Reset (i_rst_n low at a clock edge) zeros the chain digest and drops any
//   partial page.
// ----------------------------------------------------------------------------
`default_nettype none

module launch_page_digest_chain
    import lpdc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpdc_in_if.sink     i_in,
    lpdc_out_if.source  o_out
);

    t_dp_cmd    cmd;
    logic [2:0] out_index;

    lpdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .i_in_last   (i_in.word_last),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_index (out_index),
        .o_out_last  (o_out.last_word),
        .o_cmd       (cmd)
    );

    lpdc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_data_word     (i_in.data_word),
        .i_page_kind     (i_in.page_kind),
        .i_guest_address (i_in.guest_address),
        .i_out_index     (out_index),
        .o_digest_word   (o_out.digest_word)
    );

    assign o_out.digest_index = out_index;

endmodule

`default_nettype wire

/* rtl/lpdc_checker.sv */
// ----------------------------------------------------------------------------
// lpdc_checker
// Port-level checks on the digest output sequence, and that no input is taken while it is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module lpdc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_out_word,
    input wire logic [2:0]  i_out_index,
    input wire logic        i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
                                        && $stable(i_out_index))
        else $error("digest beat changed while stalled");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd5)) && (i_out_index <= 3'd5))
        else $error("digest index or last flag wrong");

    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && (i_out_index == $past(i_out_index) + 3'd1))
        else $error("digest beats not consecutive");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input taken while digest pending");

endmodule

bind launch_page_digest_chain lpdc_checker u_lpdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_index (o_out.digest_index),
    .i_out_last  (o_out.last_word)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the launch page digest chain against its own SHA-384 chain predictor.
// Directed pages, empty pages, clears and ignored beats come first. Random
// pages and partial pages follow. Sender idles at random in phases 1 and 3,
// the receiver in 2 and 3 (of 0..3). Every digest beat is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import lpdc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef logic [7:0][63:0]  t_hash;
    typedef logic [15:0][63:0] t_block;

    typedef struct {
        t_action     act;
        logic [63:0] data;
        logic        last;
        logic [2:0]  ptype;
        logic [63:0] addr;
        logic        drain;
    } t_beat;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        lst;
    } t_digest_beat;

    logic i_clk;
    logic i_rst_n;

    lpdc_in_if  in_ch();
    lpdc_out_if out_ch();

    launch_page_digest_chain u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_beat        page_beats[$];
    t_digest_beat digest_due[$];
    t_beat        cur_beat;

    logic [5:0][63:0] chain_q;
    t_hash            page_h;
    t_block           word_buf;
    logic [9:0]       word_cnt;

    int errors;
    int beats_sent;
    int beats_total;
    int pages_measured;
    int empty_pages;
    int clears;
    int digest_beats;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bswap(logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) r[i*8 +: 8] = x[(7-i)*8 +: 8];
        return r;
    endfunction

    function automatic t_hash sha_block(t_hash h, t_block b);
        logic [79:0][63:0] w;
        logic [63:0] a, bb, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = b[i];
        for (int i = 16; i < 80; i++) begin
            s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = h[0]; bb = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 80; i++) begin
            t1 = hh + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
                 + round_k(7'(i)) + w[i];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & bb) ^ (a & c) ^ (bb & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = bb; bb = a; a = t1 + t2;
        end
        h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        return h;
    endfunction

    function automatic t_hash iv384();
        t_hash h;
        for (int i = 0; i < 8; i++) h[i] = start_h(3'(i));
        return h;
    endfunction

    task automatic restart_page();
        page_h   = iv384();
        word_cnt = '0;
    endtask

    task automatic extend_chain(logic [5:0][63:0] contents, logic [2:0] ptype,
                                logic [63:0] addr);
        t_hash  h;
        t_block b;
        h = iv384();
        for (int i = 0; i < 6; i++) begin
            b[i]     = bswap(chain_q[i]);
            b[6 + i] = contents[i];
        end
        b[12] = {RECORD_LEN, 8'h00, 5'd0, ptype, 40'd0};
        b[13] = bswap(addr);
        b[14] = PAD_MARK;
        b[15] = '0;
        h = sha_block(h, b);
        b = '0;
        b[15] = RECORD_BIT_LEN;
        h = sha_block(h, b);
        for (int i = 0; i < 6; i++) begin
            chain_q[i] = bswap(h[i]);
            digest_due.push_back('{chain_q[i], 3'(i), i == 5});
        end
        pages_measured++;
    endtask

    task automatic apply_beat(t_beat bt);
        logic [3:0] p;
        case (bt.act)
            ACT_CLEAR: begin
                chain_q = '0;
                restart_page();
                clears++;
            end
            ACT_EMPTY: begin
                restart_page();
                empty_pages++;
                extend_chain('0, bt.ptype, bt.addr);
            end
            ACT_WORD: begin
                word_buf[word_cnt[3:0]] = bswap(bt.data);
                word_cnt = word_cnt + 10'd1;
                if (word_cnt[3:0] == 4'd0) page_h = sha_block(page_h, word_buf);
                if (bt.last || word_cnt >= 10'(PAGE_WORDS)) begin
                    p = word_cnt[3:0];
                    word_buf[p] = PAD_MARK;
                    for (int i = p + 1; i < 16; i++) word_buf[i] = '0;
                    if (p >= 4'd14) begin
                        page_h   = sha_block(page_h, word_buf);
                        word_buf = '0;
                    end
                    word_buf[14] = '0;
                    word_buf[15] = 64'(word_cnt) * 64;
                    page_h = sha_block(page_h, word_buf);
                    extend_chain(page_h[5:0], bt.ptype, bt.addr);
                    restart_page();
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_beat(t_action act, logic [63:0] data, logic last, logic [2:0] ptype,
                            logic [63:0] addr, logic drain = 1'b0);
        page_beats.push_back('{act, data, last, ptype, addr, drain});
    endtask

    task automatic add_page(int n, logic with_last);
        for (int i = 0; i < n; i++)
            add_beat(ACT_WORD, rand64(), with_last && (i == n - 1), 3'($urandom_range(0, 7)),
                     rand64());
    endtask

    function automatic int phase_now();
        return (beats_total == 0) ? 0 : (beats_sent * 4) / beats_total;
    endfunction

    function automatic logic sender_idle();
        case (phase_now())
            1:       return $urandom_range(0, 99) < 67;
            3:       return $urandom_range(0, 99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (phase_now())
            2:       return $urandom_range(0, 99) < 67;
            3:       return $urandom_range(0, 99) < 16;
            default: return 1'b0;
        endcase
    endfunction

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_beat(cur_beat);
                beats_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (page_beats.size() > 0 && !(page_beats[0].drain && digest_due.size() > 0)
                    && !sender_idle()) begin
                    cur_beat = page_beats.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.action        <= cur_beat.act;
                    in_ch.data_word     <= cur_beat.data;
                    in_ch.word_last     <= cur_beat.last;
                    in_ch.page_kind     <= cur_beat.ptype;
                    in_ch.guest_address <= cur_beat.addr;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Digest checker
    always @(posedge i_clk) begin
        t_digest_beat exp_b;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                digest_beats++;
                if (digest_due.size() == 0) begin
                    $display("%0t: unexpected digest beat word=%h idx=%0d last=%b", $time,
                             out_ch.digest_word, out_ch.digest_index, out_ch.last_word);
                    errors++;
                end else begin
                    exp_b = digest_due.pop_front();
                    if (out_ch.digest_word !== exp_b.word || out_ch.digest_index !== exp_b.idx
                        || out_ch.last_word !== exp_b.lst) begin
                        $display("%0t: digest mismatch exp word=%h idx=%0d last=%b", $time,
                                 exp_b.word, exp_b.idx, exp_b.lst);
                        $display("%0t:                 got word=%h idx=%0d last=%b", $time,
                                 out_ch.digest_word, out_ch.digest_index, out_ch.last_word);
                        errors++;
                    end
                end
            end
            out_ch.ready <= !receiver_stall();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest beats outstanding", cycles,
                     digest_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int kind;
        errors = 0; beats_sent = 0; beats_total = 0; pages_measured = 0;
        empty_pages = 0; clears = 0; digest_beats = 0; cycles = 0;
        chain_q = '0;
        word_buf = '0;
        restart_page();
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NONE;
        in_ch.data_word = '0;
        in_ch.word_last = 1'b0;
        in_ch.page_kind = '0;
        in_ch.guest_address = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        // directed
        add_beat(ACT_EMPTY, '0, 1'b0, 3'd0, '0);
        add_beat(ACT_EMPTY, '1, 1'b1, 3'd7, '1);
        add_beat(ACT_WORD, '1, 1'b1, 3'd1, 64'h0000_0000_fff0_0000);
        add_beat(ACT_WORD, '0, 1'b1, 3'd4, '0);
        add_beat(ACT_NONE, '1, 1'b1, 3'd7, '1);
        add_page(14, 1'b1);
        add_beat(ACT_WORD, rand64(), 1'b0, 3'd2, rand64());
        add_beat(ACT_CLEAR, rand64(), 1'b1, 3'd5, rand64());
        add_beat(ACT_WORD, rand64(), 1'b0, 3'd6, rand64());
        add_beat(ACT_EMPTY, rand64(), 1'b0, 3'd3, rand64());

        // random
        while (page_beats.size() < 420) begin
            kind = $urandom_range(0, 99);
            if (kind < 70)      add_page($urandom_range(1, 40), 1'b1);
            else if (kind < 80) add_beat(ACT_EMPTY, rand64(), 1'($urandom_range(0, 1)),
                                         3'($urandom_range(0, 7)), rand64());
            else if (kind < 85) add_beat(ACT_CLEAR, rand64(), 1'($urandom_range(0, 1)),
                                         3'($urandom_range(0, 7)), rand64());
            else if (kind < 90) add_beat(ACT_NONE, rand64(), 1'($urandom_range(0, 1)),
                                         3'($urandom_range(0, 7)), rand64());
            else                add_page($urandom_range(1, 20), 1'b0);
            if (page_beats.size() > 200 && page_beats.size() < 240)
                add_beat(ACT_EMPTY, rand64(), 1'b0, 3'($urandom_range(0, 7)), rand64(), 1'b1);
        end
        add_beat(ACT_CLEAR, '0, 1'b0, 3'd0, '0);
        add_page($urandom_range(1, 40), 1'b1);
        beats_total = page_beats.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (page_beats.size() == 0 && !in_ch.valid && digest_due.size() == 0);
        repeat (600) @(posedge i_clk);

        $display("%0d beats sent: %0d pages measured (%0d empty), %0d clears", beats_sent,
                 pages_measured, empty_pages, clears);
        $display("%0d digest beats checked, %0d errors", digest_beats, errors);
        if (errors == 0 && digest_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/lpdc_pkg.sv
rtl/lpdc_if.sv
rtl/lpdc_ctrl.sv
rtl/lpdc_dp.sv
rtl/launch_page_digest_chain.sv
rtl/lpdc_checker.sv
bench/testbench.sv
